@@ hdl/htsd_pkg.sv @@
// Package for the Huffman tree stream decoder: shared widths, status codes,
// queue sizing and the result-push struct. No dependencies.
`default_nettype none

package htsd_pkg;

  localparam int MAX_NODES_DEF   = 512;
  localparam int STACK_DEPTH_DEF = 256;

  localparam int BYTE_W   = 8;
  localparam int SYM_W    = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 31;

  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SINGLE_LEAF = 2'd2;

  // result queue: one byte can add eight items plus the two walk results of
  // the byte before it that are still unresolved when it is taken
  localparam int OUTQ_DEPTH   = 16;
  localparam int OUTQ_RESERVE = 10;

  typedef struct packed {
    logic                push;
    logic                commit;
    logic [SYM_W-1:0]    symbol;
    logic [STATUS_W-1:0] status;
    logic                fin;
  } res_push_t;

endpackage

`default_nettype wire

@@ hdl/huffman_tree_stream_decoder.sv @@
// Top level of the Huffman tree stream decoder: bit engine plus result queue.
// Depends on htsd_pkg, htsd_engine, htsd_outq (and htsd_ram below the engine).
//
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  input   | in_valid, in_stall, in_stream_byte             | in
//  result  | out_valid, out_stall, out_symbol, out_status,  | out
//          | out_final_symbol, out_last_of_item             |
//  config  | cfg_write, cfg_symbol_count                    | in
//
// Rate: one bit per clock while a byte is in flight, and the next byte is
//   taken in the cycle its predecessor's last bit is worked if the queue has
//   room. The rate is set by the node table: each walk step is one registered
//   read whose data forms the next read address.
// Walk results appear in the cycle after their bit; an item becomes visible
//   once every bit of its byte has resolved.
// Reset (rst_n low, synchronous) clears control state; the node table and the
//   stack are not cleared and need no clearing pass. A cfg_write restarts
//   tree building and loads the symbol count.
// in_stall is high while a byte is mid-flight or while the 16-entry result
//   queue holds more than 6 items; out_stall only holds the queue.
`default_nettype none

module huffman_tree_stream_decoder #(
  parameter int MAX_NODES   = htsd_pkg::MAX_NODES_DEF,
  parameter int STACK_DEPTH = htsd_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // config
  input  wire logic                          cfg_write,
  input  wire logic [htsd_pkg::COUNT_W-1:0]  cfg_symbol_count,
  // input items
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [htsd_pkg::BYTE_W-1:0]   in_stream_byte,
  // result items
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [htsd_pkg::SYM_W-1:0]         out_symbol,
  output logic [htsd_pkg::STATUS_W-1:0]      out_status,
  output logic                               out_final_symbol,
  output logic                               out_last_of_item
);

  // engine -> queue: one item pushed per cycle at most, plus byte commit
  htsd_pkg::res_push_t res;
  logic                q_room;

  htsd_engine #(
    .MAX_NODES   (MAX_NODES),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_write (cfg_write),
    .cfg_count (cfg_symbol_count),
    .in_valid  (in_valid),
    .in_byte   (in_stream_byte),
    .in_stall  (in_stall),
    .q_room    (q_room),
    .res       (res)
  );

  // results wait here until their byte is done so the last one is marked
  htsd_outq u_outq (
    .clk              (clk),
    .rst_n            (rst_n),
    .res              (res),
    .q_room           (q_room),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_symbol       (out_symbol),
    .out_status       (out_status),
    .out_final_symbol (out_final_symbol),
    .out_last_of_item (out_last_of_item)
  );

  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != htsd_pkg::ST_OK)) |->
      ((out_symbol == '0) && !out_final_symbol && out_last_of_item))
    else $error("error item with symbol data or not closing its byte");

  a_final_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_final_symbol) |-> (out_status == htsd_pkg::ST_OK))
    else $error("final symbol flag on an error item");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable({out_symbol, out_status, out_final_symbol, out_last_of_item})))
    else $error("stalled result item changed");

endmodule

`default_nettype wire

@@ hdl/htsd_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
`default_nettype none

module htsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/htsd_engine.sv @@
// Bit engine: rebuilds the preorder tree into the node table and walks it,
// one bit per cycle while a byte is in hand. Depends on htsd_pkg and htsd_ram.
`default_nettype none

module htsd_engine #(
  parameter int MAX_NODES   = htsd_pkg::MAX_NODES_DEF,
  parameter int STACK_DEPTH = htsd_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_write,
  input  wire logic [htsd_pkg::COUNT_W-1:0] cfg_count,
  input  wire logic                         in_valid,
  input  wire logic [htsd_pkg::BYTE_W-1:0]  in_byte,
  output logic                              in_stall,
  input  wire logic                         q_room,
  output htsd_pkg::res_push_t               res
);

  localparam int AW  = $clog2(MAX_NODES);
  localparam int NW  = $clog2(MAX_NODES + 1);
  localparam int EW  = 1 + ((AW > htsd_pkg::SYM_W) ? AW : htsd_pkg::SYM_W);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int LW  = $clog2(STACK_DEPTH + 1);
  localparam int BIW = $clog2(htsd_pkg::BYTE_W);

  localparam logic [1:0] PH_TAG  = 2'd0;
  localparam logic [1:0] PH_LEAF = 2'd1;
  localparam logic [1:0] PH_WALK = 2'd2;
  localparam logic [1:0] PH_HALT = 2'd3;

  localparam logic [BIW-1:0] BIT_LAST = BIW'(htsd_pkg::BYTE_W - 1);

  logic                         busy_r, busy_nxt;
  logic [htsd_pkg::BYTE_W-1:0]  byte_r, byte_nxt;
  logic [BIW-1:0]               bit_idx_r, bit_idx_nxt;
  logic [1:0]                   phase_r, phase_nxt;
  logic [AW-1:0]                build_node_r, build_node_nxt;
  logic                         from_stack_r, from_stack_nxt;
  logic [NW-1:0]                nfn_r, nfn_nxt;
  logic [LW-1:0]                level_r, level_nxt;
  logic [BIW-1:0]               leaf_cnt_r, leaf_cnt_nxt;
  logic [htsd_pkg::SYM_W-1:0]   leaf_shift_r, leaf_shift_nxt;
  logic [AW-1:0]                cur_left_r, cur_left_nxt;
  logic                         rd_pend_r, rd_pend_nxt;
  logic                         rd_last_r, rd_last_nxt;
  logic [htsd_pkg::COUNT_W-1:0] left_r, left_nxt;

  logic                tbl_we;
  logic [AW-1:0]       tbl_waddr, tbl_raddr;
  logic [EW-1:0]       tbl_wdata, tbl_rdata;
  logic                stk_we;
  logic [SAW-1:0]      stk_waddr, stk_raddr;
  logic [AW-1:0]       stk_wdata, stk_rdata;

  logic                         can_start, take, step, bit_v, res_leaf, walk_issue;
  logic [AW-1:0]                build_cur, cur_eff;
  logic [htsd_pkg::COUNT_W-1:0] left_eff;
  logic [htsd_pkg::SYM_W-1:0]   leaf_sym;
  logic [LW-1:0]                level_m1;

  htsd_ram #(.WIDTH(EW), .DEPTH(MAX_NODES)) u_node_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  htsd_ram #(.WIDTH(AW), .DEPTH(STACK_DEPTH)) u_right_stk (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign can_start = (!busy_r || (bit_idx_r == BIT_LAST)) && q_room;
  assign in_stall  = !can_start;
  assign take      = in_valid && can_start;
  assign step      = busy_r;

  always_comb begin
    bit_v     = byte_r[bit_idx_r];
    build_cur = from_stack_r ? stk_rdata : build_node_r;
    res_leaf  = rd_pend_r && tbl_rdata[EW-1];
    left_eff  = res_leaf ? (left_r - htsd_pkg::COUNT_W'(1)) : left_r;
    if (!rd_pend_r) begin
      cur_eff = cur_left_r;
    end else if (tbl_rdata[EW-1]) begin
      cur_eff = AW'(1);
    end else begin
      cur_eff = tbl_rdata[AW-1:0];
    end
    leaf_sym = leaf_shift_r | (htsd_pkg::SYM_W'(bit_v) << leaf_cnt_r);
    level_m1 = level_r - LW'(1);

    busy_nxt       = busy_r;
    byte_nxt       = byte_r;
    bit_idx_nxt    = bit_idx_r;
    phase_nxt      = phase_r;
    build_node_nxt = build_cur;
    from_stack_nxt = 1'b0;
    nfn_nxt        = nfn_r;
    level_nxt      = level_r;
    leaf_cnt_nxt   = leaf_cnt_r;
    leaf_shift_nxt = leaf_shift_r;
    cur_left_nxt   = cur_eff;
    rd_pend_nxt    = 1'b0;
    rd_last_nxt    = rd_last_r;
    left_nxt       = left_eff;
    walk_issue     = 1'b0;

    tbl_we    = 1'b0;
    tbl_waddr = build_cur;
    tbl_wdata = EW'(nfn_r[AW-1:0]);
    tbl_raddr = cur_eff + AW'(bit_v);
    stk_we    = 1'b0;
    stk_waddr = level_r[SAW-1:0];
    stk_wdata = nfn_r[AW-1:0] + AW'(1);
    stk_raddr = level_m1[SAW-1:0];

    res        = '0;
    res.status = htsd_pkg::ST_OK;
    // walk read from the previous bit resolves here
    if (res_leaf) begin
      res.push   = 1'b1;
      res.symbol = tbl_rdata[htsd_pkg::SYM_W-1:0];
      res.fin    = (left_eff == '0);
    end

    if (step) begin
      unique case (phase_r)
        PH_TAG: begin
          if (bit_v) begin
            if ((nfn_r > NW'(MAX_NODES - 2)) || (level_r == LW'(STACK_DEPTH))) begin
              res.push   = 1'b1;
              res.status = htsd_pkg::ST_OVERFLOW;
              phase_nxt  = PH_HALT;
            end else begin
              tbl_we         = 1'b1;
              stk_we         = 1'b1;
              level_nxt      = level_r + LW'(1);
              build_node_nxt = nfn_r[AW-1:0];
              nfn_nxt        = nfn_r + NW'(2);
            end
          end else begin
            phase_nxt      = PH_LEAF;
            leaf_cnt_nxt   = '0;
            leaf_shift_nxt = '0;
          end
        end
        PH_LEAF: begin
          leaf_shift_nxt = leaf_sym;
          leaf_cnt_nxt   = leaf_cnt_r + BIW'(1);
          if (leaf_cnt_r == BIT_LAST) begin
            leaf_cnt_nxt = '0;
            tbl_we       = 1'b1;
            tbl_wdata    = {1'b1, (EW-1)'(leaf_sym)};
            if (level_r != '0) begin
              // pop: right child index arrives from the stack next cycle
              level_nxt      = level_m1;
              from_stack_nxt = 1'b1;
              phase_nxt      = PH_TAG;
            end else if (build_cur == '0) begin
              res.push   = 1'b1;
              res.status = htsd_pkg::ST_SINGLE_LEAF;
              phase_nxt  = PH_HALT;
            end else begin
              phase_nxt    = PH_WALK;
              cur_left_nxt = AW'(1);
            end
          end
        end
        PH_WALK: begin
          if (left_eff != '0) begin
            walk_issue  = 1'b1;
            rd_pend_nxt = 1'b1;
            rd_last_nxt = (bit_idx_r == BIT_LAST);
          end
        end
        PH_HALT: begin
        end
        default: begin
        end
      endcase
    end

    res.commit = (rd_pend_r && rd_last_r) ||
                 (step && (bit_idx_r == BIT_LAST) && !walk_issue);

    if (step) begin
      if (bit_idx_r == BIT_LAST) begin
        busy_nxt = 1'b0;
      end
      bit_idx_nxt = bit_idx_r + BIW'(1);
    end
    if (take) begin
      busy_nxt    = 1'b1;
      byte_nxt    = in_byte;
      bit_idx_nxt = '0;
    end

    if (cfg_write) begin
      phase_nxt      = PH_TAG;
      build_node_nxt = '0;
      from_stack_nxt = 1'b0;
      nfn_nxt        = NW'(1);
      level_nxt      = '0;
      leaf_cnt_nxt   = '0;
      leaf_shift_nxt = '0;
      cur_left_nxt   = AW'(1);
      rd_pend_nxt    = 1'b0;
      left_nxt       = cfg_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      bit_idx_r    <= '0;
      phase_r      <= PH_TAG;
      build_node_r <= '0;
      from_stack_r <= 1'b0;
      nfn_r        <= NW'(1);
      level_r      <= '0;
      leaf_cnt_r   <= '0;
      leaf_shift_r <= '0;
      cur_left_r   <= AW'(1);
      rd_pend_r    <= 1'b0;
      rd_last_r    <= 1'b0;
      left_r       <= '0;
    end else begin
      busy_r       <= busy_nxt;
      bit_idx_r    <= bit_idx_nxt;
      phase_r      <= phase_nxt;
      build_node_r <= build_node_nxt;
      from_stack_r <= from_stack_nxt;
      nfn_r        <= nfn_nxt;
      level_r      <= level_nxt;
      leaf_cnt_r   <= leaf_cnt_nxt;
      leaf_shift_r <= leaf_shift_nxt;
      cur_left_r   <= cur_left_nxt;
      rd_pend_r    <= rd_pend_nxt;
      rd_last_r    <= rd_last_nxt;
      left_r       <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  a_pend_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (phase_r == PH_WALK))
    else $error("walk read outstanding outside the walk phase");

  a_pop_to_tag: assert property (@(posedge clk) disable iff (!rst_n)
    from_stack_r |-> (phase_r == PH_TAG))
    else $error("stack pop not followed by a tag bit");

  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (res.push && (res.status != htsd_pkg::ST_OK) && !cfg_write) |=> (phase_r == PH_HALT))
    else $error("error item without halt");

  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (level_r <= LW'(STACK_DEPTH)) && (nfn_r <= NW'(MAX_NODES)))
    else $error("stack level or free node index out of range");

endmodule

`default_nettype wire

@@ hdl/htsd_outq.sv @@
// Result queue: items of a byte are held back until the byte is committed,
// so the last one can be marked. Depends on htsd_pkg.
`default_nettype none

module htsd_outq (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire htsd_pkg::res_push_t           res,
  output logic                               q_room,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [htsd_pkg::SYM_W-1:0]         out_symbol,
  output logic [htsd_pkg::STATUS_W-1:0]      out_status,
  output logic                               out_final_symbol,
  output logic                               out_last_of_item
);

  localparam int DEPTH = htsd_pkg::OUTQ_DEPTH;
  localparam int IW    = $clog2(DEPTH);
  localparam int PW    = IW + 1;

  logic [PW-1:0] wr_r, rd_r, cm_r;
  logic [PW-1:0] wr_nxt, rd_nxt, cm_nxt, count, wr_m1;

  logic [htsd_pkg::SYM_W-1:0]    sym_r  [DEPTH];
  logic [htsd_pkg::STATUS_W-1:0] st_r   [DEPTH];
  logic                          fin_r  [DEPTH];
  logic                          last_r [DEPTH];

  logic pop;

  assign count     = wr_r - rd_r;
  assign q_room    = (count <= PW'(DEPTH - htsd_pkg::OUTQ_RESERVE));
  assign out_valid = (rd_r != cm_r);
  assign pop       = out_valid && !out_stall;
  assign wr_nxt    = wr_r + PW'(res.push);
  assign rd_nxt    = rd_r + PW'(pop);
  assign cm_nxt    = res.commit ? wr_nxt : cm_r;
  assign wr_m1     = wr_r - PW'(1);

  assign out_symbol       = sym_r[rd_r[IW-1:0]];
  assign out_status       = st_r[rd_r[IW-1:0]];
  assign out_final_symbol = fin_r[rd_r[IW-1:0]];
  assign out_last_of_item = last_r[rd_r[IW-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cm_r <= '0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
      cm_r <= cm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.push) begin
      sym_r[wr_r[IW-1:0]]  <= res.symbol;
      st_r[wr_r[IW-1:0]]   <= res.status;
      fin_r[wr_r[IW-1:0]]  <= res.fin;
      last_r[wr_r[IW-1:0]] <= res.commit;
    end else if (res.commit && (wr_r != cm_r)) begin
      last_r[wr_m1[IW-1:0]] <= 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count <= PW'(DEPTH))
    else $error("result queue overflow");

  a_commit_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (cm_r - rd_r) <= count)
    else $error("commit pointer beyond write pointer");

  a_commit_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res.commit && !res.push && (wr_r != cm_r)) |=> last_r[$past(wr_m1[IW-1:0])])
    else $error("committed byte lost its last mark");

endmodule

`default_nettype wire

@@ test/huffman_tree_stream_decoder_tb.sv @@
// Self-checking testbench for huffman_tree_stream_decoder: builds preorder
// trees and coded bitstreams, predicts every result and checks it on out_*.
// Depends on htsd_pkg and the RTL below hdl/.
`default_nettype none

module huffman_tree_stream_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODE_AW      = $clog2(htsd_pkg::MAX_NODES_DEF);
  localparam int DRAIN_CYCLES = 32;
  localparam int RANDOM_ITEMS = 270;

  // one table slot: leaf flag plus symbol, or index of the left child
  typedef struct packed {
    logic               leaf;
    logic [NODE_AW-1:0] link;
  } tree_entry_t;

  typedef struct packed {
    logic [htsd_pkg::SYM_W-1:0]    symbol;
    logic [htsd_pkg::STATUS_W-1:0] status;
    logic                          fin;
    logic                          last;
  } decoded_t;

  typedef enum logic [1:0] {TAG_BIT, LEAF_BITS, TREE_WALK, HALTED} dec_phase_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_write = 1'b0;
  logic [htsd_pkg::COUNT_W-1:0]  cfg_symbol_count = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [htsd_pkg::BYTE_W-1:0]   in_stream_byte = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [htsd_pkg::SYM_W-1:0]    out_symbol;
  logic [htsd_pkg::STATUS_W-1:0] out_status;
  logic                          out_final_symbol;
  logic                          out_last_of_item;

  // decoder state as seen by the predictor
  tree_entry_t                  tree_node [htsd_pkg::MAX_NODES_DEF];
  logic [NODE_AW-1:0]           right_stack [htsd_pkg::STACK_DEPTH_DEF];
  int                           stack_level;
  dec_phase_t                   dec_phase;
  logic [NODE_AW-1:0]           build_at;
  int                           next_free;
  int                           leaf_bits;
  logic [7:0]                   leaf_sym;
  logic [NODE_AW-1:0]           walk_at;
  logic [htsd_pkg::COUNT_W-1:0] symbols_left;

  decoded_t decoded_q [$];   // results predicted, not yet seen on out_*
  decoded_t oldest;
  int       mismatches = 0;
  logic     steady = 1'b0;   // no idling on either side while set

  // stream under construction, bit 0 first, plus the code of each leaf
  bit          stream_bits [$];
  logic [63:0] leaf_code [$];
  int          leaf_len [$];
  logic [7:0]  preset_syms [$];   // leaf symbols to use before random ones

  huffman_tree_stream_decoder u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write        (cfg_write),
    .cfg_symbol_count (cfg_symbol_count),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_stream_byte   (in_stream_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_symbol       (out_symbol),
    .out_status       (out_status),
    .out_final_symbol (out_final_symbol),
    .out_last_of_item (out_last_of_item)
  );

  always #6 clk = ~clk;

  // receiver holds off about 9 percent of the time unless in a steady stretch
  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 9);
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // restart as a count write does; the table is cleared for tidiness only,
  // the walk never reads a slot the current tree did not write
  task automatic restart_decoder(input logic [htsd_pkg::COUNT_W-1:0] n);
    foreach (tree_node[k]) tree_node[k] = '0;
    foreach (right_stack[k]) right_stack[k] = '0;
    stack_level  = 0;
    dec_phase    = TAG_BIT;
    build_at     = '0;
    next_free    = 1;
    leaf_bits    = 0;
    leaf_sym     = '0;
    walk_at      = '0;
    symbols_left = n;
  endtask

  // works the eight bits of one accepted byte, LSB first, and queues the
  // results it causes
  task automatic decode_byte(input logic [7:0] b);
    decoded_t           made [$];
    logic [NODE_AW-1:0] child;
    logic               stop;
    stop = 1'b0;
    for (int i = 0; i < 8 && !stop; i++) begin
      case (dec_phase)
        TAG_BIT: begin
          if (b[i]) begin
            // internal node: children take the next two free slots
            if (next_free + 2 > htsd_pkg::MAX_NODES_DEF ||
                stack_level >= htsd_pkg::STACK_DEPTH_DEF) begin
              made.push_back('{symbol: '0, status: htsd_pkg::ST_OVERFLOW,
                               fin: 1'b0, last: 1'b0});
              dec_phase = HALTED;
              stop = 1'b1;
            end else begin
              tree_node[build_at] = '{leaf: 1'b0, link: NODE_AW'(next_free)};
              right_stack[stack_level] = NODE_AW'(next_free + 1);
              stack_level++;
              build_at = NODE_AW'(next_free);
              next_free += 2;
            end
          end else begin
            dec_phase = LEAF_BITS;
            leaf_bits = 0;
            leaf_sym  = '0;
          end
        end
        LEAF_BITS: begin
          leaf_sym[leaf_bits] = b[i];
          leaf_bits++;
          if (leaf_bits == 8) begin
            leaf_bits = 0;
            tree_node[build_at] = '{leaf: 1'b1, link: NODE_AW'(leaf_sym)};
            if (stack_level > 0) begin
              stack_level--;
              build_at  = right_stack[stack_level];
              dec_phase = TAG_BIT;
            end else if (build_at == 0) begin
              // the whole tree is one root leaf
              made.push_back('{symbol: '0, status: htsd_pkg::ST_SINGLE_LEAF,
                               fin: 1'b0, last: 1'b0});
              dec_phase = HALTED;
              stop = 1'b1;
            end else begin
              dec_phase = TREE_WALK;
              walk_at   = '0;
            end
          end
        end
        TREE_WALK: begin
          if (symbols_left == 0) begin
            stop = 1'b1;   // count reached, rest ignored
          end else begin
            child = tree_node[walk_at].link + NODE_AW'(b[i]);
            if (tree_node[child].leaf) begin
              symbols_left--;
              made.push_back('{symbol: tree_node[child].link[htsd_pkg::SYM_W-1:0],
                               status: htsd_pkg::ST_OK,
                               fin: (symbols_left == 0), last: 1'b0});
              walk_at = '0;
            end else begin
              walk_at = child;
            end
          end
        end
        default: begin
          stop = 1'b1;
        end
      endcase
    end
    if (made.size() > 0) made[made.size() - 1].last = 1'b1;
    foreach (made[k]) decoded_q.push_back(made[k]);
  endtask

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Preorder tree with exactly `leaves` leaves, random shape. Records the
  // walk code of each leaf; the right child of every internal node waits
  // on a local stack just as in the block.
  task automatic build_tree_bits(input int leaves);
    logic [63:0] path_code;
    logic [63:0] code_stack [$];
    int          len_stack [$];
    int          path_len, open_slots, internals;
    logic [7:0]  sym;
    leaf_code.delete();
    leaf_len.delete();
    path_code  = '0;
    path_len   = 0;
    open_slots = 1;
    internals  = 0;
    while (open_slots > 0) begin
      // an open slot left alone would close the tree early
      if (internals < leaves - 1 && (open_slots == 1 || $urandom_range(1) == 1)) begin
        stream_bits.push_back(1'b1);
        code_stack.push_back(path_code | (64'd1 << path_len));
        len_stack.push_back(path_len + 1);
        path_len++;
        internals++;
        open_slots++;
      end else begin
        stream_bits.push_back(1'b0);
        sym = (preset_syms.size() > 0) ? preset_syms.pop_front() : 8'($urandom);
        for (int k = 0; k < 8; k++) stream_bits.push_back(sym[k]);
        leaf_code.push_back(path_code);
        leaf_len.push_back(path_len);
        open_slots--;
        if (code_stack.size() > 0) begin
          path_code = code_stack.pop_back();
          path_len  = len_stack.pop_back();
        end
      end
    end
  endtask

  task automatic add_code(input int idx);
    for (int k = 0; k < leaf_len[idx]; k++) stream_bits.push_back(leaf_code[idx][k]);
  endtask

  task automatic add_random_bits(input int n);
    repeat (n) stream_bits.push_back(1'($urandom_range(1)));
  endtask

  // Offers one byte; called and left at a falling edge. Valid drops only
  // for a random gap, so back-to-back items keep it high.
  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_stream_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_byte(b);
    @(negedge clk);
  endtask

  // pads the pending bits to whole bytes and sends them
  task automatic send_bits(output int bytes);
    logic [7:0] b;
    add_random_bits((8 - stream_bits.size() % 8) % 8);
    bytes = stream_bits.size() / 8;
    while (stream_bits.size() > 0) begin
      for (int k = 0; k < 8; k++) b[k] = stream_bits.pop_front();
      send_byte(b);
    end
    in_valid <= 1'b0;
  endtask

  // all predicted results seen, then room for a byte that made none
  task automatic wait_idle();
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_count(input logic [htsd_pkg::COUNT_W-1:0] n);
    wait_idle();
    cfg_write        <= 1'b1;
    cfg_symbol_count <= n;
    @(negedge clk);
    cfg_write <= 1'b0;
    restart_decoder(n);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // count is zero out of reset: a complete tree and walk bits give nothing
  task automatic test_reset_state();
    int n;
    preset_syms.push_back(8'h3C);
    preset_syms.push_back(8'hC3);
    build_tree_bits(2);
    add_code(0);
    add_code(1);
    send_bits(n);
  endtask

  // all-zero and all-one symbols, final flag, then bytes past the count
  task automatic test_extreme_symbols();
    int n;
    write_count(4);
    preset_syms.push_back(8'h00);
    preset_syms.push_back(8'hFF);
    preset_syms.push_back(8'h81);
    build_tree_bits(3);
    add_code(0);
    add_code(1);
    add_code(2);
    add_code(1);
    add_random_bits(8);
    send_bits(n);
    send_byte(8'h00);   // count reached: ignored
    in_valid <= 1'b0;
  endtask

  // a root leaf errors out even with a zero count; the block then halts
  task automatic test_single_leaf();
    int n;
    write_count(0);
    stream_bits.push_back(1'b0);
    for (int k = 0; k < 8; k++) stream_bits.push_back(k[0]);
    send_bits(n);
    send_byte(8'hFF);   // halted: ignored
    in_valid <= 1'b0;
  endtask

  // largest count: symbols flow, none is final
  task automatic test_max_count();
    int n;
    write_count('1);
    build_tree_bits(5);
    repeat (10) add_code($urandom_range(4));
    send_bits(n);
  endtask

  // an all-internal chain runs out of node slots
  task automatic test_table_overflow();
    write_count(3);
    repeat (32) send_byte(8'hFF);
    send_byte(8'($urandom));   // halted: ignored
    send_byte(8'($urandom));
    in_valid <= 1'b0;
  endtask

  // Mostly well-formed trees and symbol streams with random content; the
  // rest is noise or a tree cut short. One stretch runs with no idling.
  task automatic test_random_streams();
    int sent, phase_no, roll, leaves, n, cut;
    sent     = 0;
    phase_no = 0;
    while (sent < RANDOM_ITEMS) begin
      steady = (phase_no >= 8 && phase_no < 14);
      roll = $urandom_range(99);
      if (roll < 80) begin
        n = $urandom_range(1, 20);
        if ($urandom_range(9) == 0) write_count(htsd_pkg::COUNT_W'($urandom));
        else write_count(n);
        roll   = $urandom_range(99);
        leaves = (roll < 80) ? $urandom_range(2, 10) :
                 (roll < 95) ? $urandom_range(11, 40) : $urandom_range(41, 60);
        build_tree_bits(leaves);
        // sometimes a few symbols past the count
        repeat (n + $urandom_range(0, 2)) add_code($urandom_range(leaves - 1));
      end else if (roll < 90) begin
        write_count($urandom_range(0, 30));
        add_random_bits(8 * $urandom_range(2, 16));
      end else begin
        write_count($urandom_range(1, 20));
        build_tree_bits($urandom_range(1, 12));
        cut = $urandom_range(stream_bits.size());
        while (stream_bits.size() > cut) void'(stream_bits.pop_back());
        add_random_bits($urandom_range(0, 40));
      end
      send_bits(n);
      sent += n;
      phase_no++;
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, got symbol %0h status %0d",
                 $time, out_symbol, out_status);
        mismatches++;
      end else begin
        oldest = decoded_q.pop_front();
        check_field("symbol", oldest.symbol, out_symbol);
        check_field("status", oldest.status, out_status);
        check_field("final_symbol", oldest.fin, out_final_symbol);
        check_field("last_of_item", oldest.last, out_last_of_item);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    restart_decoder('0);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_extreme_symbols();
    test_single_leaf();
    test_max_count();
    test_table_overflow();
    test_random_streams();
    wait_idle();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // a correct run needs well under a tenth of this
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

@@ huffman_tree_stream_decoder.f @@
hdl/htsd_pkg.sv
hdl/htsd_ram.sv
hdl/htsd_engine.sv
hdl/htsd_outq.sv
hdl/huffman_tree_stream_decoder.sv
test/huffman_tree_stream_decoder_tb.sv
